### design/deq_pkg.sv
// shared constants and types for the double-ended queue
package deq_pkg;

    localparam int DEPTH        = 16;
    localparam int WORD_BITS    = 32;
    localparam int IDX_BITS     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS     = $clog2(DEPTH + 1);
    localparam int SUM_BITS     = $clog2(2 * DEPTH);
    localparam int VALUE_BITS   = 32;
    localparam int COUNT_BITS   = 5;

    typedef logic [WORD_BITS-1:0]  t_word;
    typedef logic [IDX_BITS-1:0]   t_idx;
    typedef logic [CNT_BITS-1:0]   t_cnt;
    typedef logic [SUM_BITS-1:0]   t_sum;

    typedef enum logic [1:0] {
        CMD_PUSH_FRONT = 2'd0,
        CMD_PUSH_BACK  = 2'd1,
        CMD_POP_FRONT  = 2'd2,
        CMD_REVERSE    = 2'd3
    } t_command;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_EXEC   = 3'b010,
        ST_RESULT = 3'b100
    } t_state;

    typedef struct packed {
        logic load;
        logic exec;
    } t_dp_ctrl;

endpackage

### design/deq_if.sv
// request and result channel interfaces
interface deq_cmd_if;
    logic                                  valid;
    logic                                  ready;
    deq_pkg::t_command                     command;
    logic signed [deq_pkg::VALUE_BITS-1:0] value;

    modport source (output valid, output command, output value, input ready);
    modport sink   (input valid, input command, input value, output ready);
endinterface

interface deq_rsp_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  ok;
    logic signed [deq_pkg::VALUE_BITS-1:0] removed_value;
    logic [deq_pkg::COUNT_BITS-1:0]        count;

    modport source (output valid, output ok, output removed_value, output count, input ready);
    modport sink   (input valid, input ok, input removed_value, input count, output ready);
endinterface

### design/deq_ctrl.sv
// controller state machine: accept, execute, hold result
module deq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    output logic              o_cmd_ready,
    output logic              o_rsp_valid,
    input  logic              i_rsp_ready,
    output deq_pkg::t_dp_ctrl o_ctrl
);
    import deq_pkg::*;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state = ST_RESULT;
            end
            ST_RESULT: begin
                if (i_rsp_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd_ready = (r_state == ST_IDLE);
    assign o_rsp_valid = (r_state == ST_RESULT);
    assign o_ctrl.load = (r_state == ST_IDLE) && i_cmd_valid;
    assign o_ctrl.exec = (r_state == ST_EXEC);

endmodule

### design/deq_dp.sv
// datapath: ring storage, pointers, orientation and result registers
module deq_dp (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  deq_pkg::t_dp_ctrl                     i_ctrl,
    input  deq_pkg::t_command                     i_command,
    input  logic signed [deq_pkg::VALUE_BITS-1:0] i_value,
    output logic                                  o_ok,
    output logic signed [deq_pkg::VALUE_BITS-1:0] o_removed_value,
    output logic [deq_pkg::COUNT_BITS-1:0]        o_count
);
    import deq_pkg::*;

    t_word    r_mem [DEPTH];
    t_word    r_rd_data;

    t_command r_cmd;
    t_word    r_word;
    t_idx     r_front;
    t_idx     n_front;
    t_cnt     r_count;
    t_cnt     n_count;
    logic     r_rev;
    logic     n_rev;
    logic     r_ok;
    logic     n_ok;
    logic     r_popped;
    logic     n_popped;

    logic     full;
    logic     empty;
    logic     at_front;
    t_idx     front_dec;
    t_idx     front_inc;
    t_sum     sum;
    t_sum     sum_m1;
    t_idx     back_put;
    t_idx     back_last;
    logic     we;
    t_idx     wa;
    logic     re;
    t_idx     ra;

    assign full     = (r_count == t_cnt'(DEPTH));
    assign empty    = (r_count == '0);
    assign at_front = (r_cmd == CMD_PUSH_FRONT) != r_rev;

    assign front_dec = (r_front == '0) ? t_idx'(DEPTH - 1) : r_front - t_idx'(1);
    assign front_inc = (r_front == t_idx'(DEPTH - 1)) ? '0 : r_front + t_idx'(1);

    // physical slot one past the back, and the back slot itself
    assign sum      = t_sum'(r_front) + t_sum'(r_count);
    assign sum_m1   = sum - t_sum'(1);
    assign back_put = (sum >= t_sum'(DEPTH)) ? t_idx'(sum - t_sum'(DEPTH)) : t_idx'(sum);
    assign back_last = (sum_m1 >= t_sum'(DEPTH)) ? t_idx'(sum_m1 - t_sum'(DEPTH))
                                                 : t_idx'(sum_m1);

    always_comb begin
        n_front  = r_front;
        n_count  = r_count;
        n_rev    = r_rev;
        n_ok     = 1'b0;
        n_popped = 1'b0;
        we       = 1'b0;
        wa       = back_put;
        re       = 1'b0;
        ra       = r_front;
        unique case (r_cmd)
            CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                if (!full) begin
                    n_ok    = 1'b1;
                    we      = 1'b1;
                    n_count = r_count + t_cnt'(1);
                    if (at_front) begin
                        wa      = front_dec;
                        n_front = front_dec;
                    end
                end
            end
            CMD_POP_FRONT: begin
                if (!empty) begin
                    n_ok     = 1'b1;
                    n_popped = 1'b1;
                    re       = 1'b1;
                    n_count  = r_count - t_cnt'(1);
                    if (r_rev) begin
                        ra = back_last;
                    end else begin
                        n_front = front_inc;
                    end
                end
            end
            CMD_REVERSE: begin
                n_ok  = 1'b1;
                n_rev = ~r_rev;
            end
            default: begin
                n_ok = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_count <= '0;
            r_rev   <= 1'b0;
        end else if (i_ctrl.exec) begin
            r_front <= n_front;
            r_count <= n_count;
            r_rev   <= n_rev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_cmd  <= i_command;
            r_word <= t_word'($unsigned(i_value));
        end
        if (i_ctrl.exec) begin
            r_ok     <= n_ok;
            r_popped <= n_popped;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.exec && we) begin
            r_mem[wa] <= r_word;
        end
        if (i_ctrl.exec && re) begin
            r_rd_data <= r_mem[ra];
        end
    end

    assign o_ok            = r_ok;
    assign o_removed_value = r_popped ? VALUE_BITS'(r_rd_data) : '0;
    assign o_count         = COUNT_BITS'(r_count);

endmodule

### design/double_ended_queue.sv
// top level: bounded double-ended queue of signed words
// sequence: request accepted in idle, executed the next cycle, result valid the cycle after
// one request at a time: a new request is accepted only after the last result is taken,
//   set by the idle/execute/result sequence of the controller
// reset: synchronous active-low i_rst_n empties the queue and restores normal orientation;
//   entry storage is not cleared and no clearing pass is needed
module double_ended_queue (
    input  logic       i_clk,
    input  logic       i_rst_n,
    deq_cmd_if.sink    i_cmd,
    deq_rsp_if.source  o_rsp
);
    import deq_pkg::*;

    // command bundle from controller to datapath
    t_dp_ctrl ctrl;

    // controller owns the handshakes: ready only when idle, valid only while
    // the result is held
    deq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (i_cmd.valid),
        .o_cmd_ready (i_cmd.ready),
        .o_rsp_valid (o_rsp.valid),
        .i_rsp_ready (o_rsp.ready),
        .o_ctrl      (ctrl)
    );

    // datapath captures the request, updates ring pointers, count and orientation,
    // and keeps the result stable until it is taken
    deq_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctrl          (ctrl),
        .i_command       (i_cmd.command),
        .i_value         (i_cmd.value),
        .o_ok            (o_rsp.ok),
        .o_removed_value (o_rsp.removed_value),
        .o_count         (o_rsp.count)
    );

endmodule

### sim/tb.sv
// self-checking testbench for the double-ended queue with its own deque mirror
`timescale 1ns / 1ps

module tb;
    import deq_pkg::*;

    localparam int LONG_HOLD   = 200;
    localparam int DRAIN_LIMIT = 2000;
    localparam int ITEM_TARGET = 1350;

    // one expected result per accepted request
    typedef struct {
        logic                  ok;
        logic [VALUE_BITS-1:0] removed;
        logic [COUNT_BITS-1:0] count;
    } t_deque_result;

    // mirror of the ring: slot store, physical front, fill level, orientation,
    // plus the fifo of results still owed by the block
    class deque_mirror;
        t_word         slots[DEPTH];
        int            front;
        int            held;
        bit            flipped;
        t_deque_result owed[$];
        int            fail_count;

        function int pending();
            return owed.size();
        endfunction

        function void report(string msg);
            if (fail_count < 10)
                $display("[%0t] mismatch: %s", $realtime, msg);
            fail_count++;
        endfunction

        // apply one accepted request to the mirror and queue its result
        function void note_request(t_command c, logic signed [VALUE_BITS-1:0] v);
            t_deque_result r;
            bit            at_phys_front;
            r.ok      = 1'b0;
            r.removed = '0;
            case (c)
                CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                    if (held < DEPTH) begin
                        // pushing at the logical front of a reversed queue
                        // lands on the physical back and vice versa
                        at_phys_front = (c == CMD_PUSH_FRONT) != flipped;
                        if (at_phys_front) begin
                            front        = (front + DEPTH - 1) % DEPTH;
                            slots[front] = t_word'(v);
                        end else begin
                            slots[(front + held) % DEPTH] = t_word'(v);
                        end
                        held++;
                        r.ok = 1'b1;
                    end
                end
                CMD_POP_FRONT: begin
                    if (held > 0) begin
                        if (flipped) begin
                            r.removed = slots[(front + held + DEPTH - 1) % DEPTH];
                        end else begin
                            r.removed = slots[front];
                            front     = (front + 1) % DEPTH;
                        end
                        held--;
                        r.ok = 1'b1;
                    end
                end
                default: begin
                    // reverse only toggles orientation, even when empty
                    flipped = ~flipped;
                    r.ok    = 1'b1;
                end
            endcase
            r.count = COUNT_BITS'(held);
            owed.push_back(r);
        endfunction

        function void check_result(logic ok, logic [VALUE_BITS-1:0] removed,
                                   logic [COUNT_BITS-1:0] count);
            t_deque_result e;
            if (owed.size() == 0) begin
                report($sformatf("result with no request pending: ok=%0b removed=%h count=%0d",
                                 ok, removed, count));
                return;
            end
            e = owed.pop_front();
            if (ok !== e.ok)
                report($sformatf("ok: expected %0b, got %0b", e.ok, ok));
            if (removed !== e.removed)
                report($sformatf("removed_value: expected %h, got %h", e.removed, removed));
            if (count !== e.count)
                report($sformatf("count: expected %0d, got %0d", e.count, count));
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    deq_cmd_if   cmd_bus();
    deq_rsp_if   rsp_bus();
    deque_mirror track = new();
    int          long_hold_req = 0;

    always #5 i_clk = ~i_clk;

    double_ended_queue uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_bus),
        .o_rsp   (rsp_bus)
    );

    // result monitor: values seen here are the ones from before the edge
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_bus.valid && rsp_bus.ready)
            track.check_result(rsp_bus.ok, rsp_bus.removed_value, rsp_bus.count);
    end

    // receiver: window-based stall pattern, plus a long hold-off on demand
    initial begin
        int       hold_left;
        int       holds_given;
        int       window_left;
        int       mode;
        bit [7:0] mask;
        hold_left   = 0;
        holds_given = 0;
        window_left = 0;
        mode        = 0;
        mask        = 8'hff;
        rsp_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left == 0 && long_hold_req != holds_given) begin
                hold_left = LONG_HOLD;
                holds_given++;
            end
            if (window_left == 0) begin
                window_left = $urandom_range(16, 80);
                mode        = $urandom_range(3);
                mask        = 8'($urandom);
            end
            window_left--;
            if (hold_left > 0) begin
                // long stall: results back up and the request side blocks
                hold_left--;
                rsp_bus.ready <= 1'b0;
            end else begin
                case (mode)
                    0: rsp_bus.ready <= 1'b1;                        // no stalls at all
                    1: rsp_bus.ready <= 1'($urandom);                // coin flip
                    2: rsp_bus.ready <= ($urandom_range(3) == 0);    // mostly stalled
                    default: begin                                   // rotating mask
                        rsp_bus.ready <= mask[0];
                        mask = {mask[0], mask[7:1]};
                    end
                endcase
            end
        end
    end

    // corner words show up often, otherwise a full-range random word
    function automatic logic signed [VALUE_BITS-1:0] pick_word();
        case ($urandom_range(11))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // offer one request and hold it until the block takes it
    task automatic send_request(t_command c, logic signed [VALUE_BITS-1:0] v);
        cmd_bus.valid   <= 1'b1;
        cmd_bus.command <= c;
        cmd_bus.value   <= v;
        @(posedge i_clk);
        while (!cmd_bus.ready)
            @(posedge i_clk);
        track.note_request(c, v);
    endtask

    task automatic sender_gap(int cycles);
        cmd_bus.valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // stop offering until every owed result has come back
    task automatic wait_drained();
        cmd_bus.valid <= 1'b0;
        do
            @(posedge i_clk);
        while (track.pending() != 0);
    endtask

    initial begin
        int       sent;
        int       burst_left;
        int       waited;
        int       roll;
        bit       tide_rising;
        t_command c;

        i_rst_n         <= 1'b0;
        cmd_bus.valid   <= 1'b0;
        cmd_bus.command <= CMD_PUSH_FRONT;
        cmd_bus.value   <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty pop, reverse on empty and on a single entry
        send_request(CMD_POP_FRONT, pick_word());
        send_request(CMD_REVERSE, pick_word());
        send_request(CMD_REVERSE, pick_word());
        send_request(CMD_PUSH_FRONT, 32'sh7fff_ffff);
        send_request(CMD_REVERSE, pick_word());
        send_request(CMD_POP_FRONT, pick_word());
        send_request(CMD_REVERSE, pick_word());
        // fill to the brim from both ends, then push into a full queue
        for (int i = 0; i < DEPTH; i++) begin
            c = (i % 2 == 0) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
            case (i)
                0:       send_request(c, 32'sh8000_0000);
                1:       send_request(c, 32'sh7fff_ffff);
                2:       send_request(c, '0);
                3:       send_request(c, '1);
                default: send_request(c, $urandom);
            endcase
        end
        send_request(CMD_PUSH_BACK, pick_word());
        send_request(CMD_PUSH_FRONT, pick_word());

        // random: tide between filling and draining so both full and empty
        // are hit over and over, with reverses sprinkled in
        sent        = 0;
        burst_left  = 0;
        tide_rising = 1'b0;
        while (sent < ITEM_TARGET) begin
            if (sent == 400 || sent == 950)
                long_hold_req++;               // sender keeps offering meanwhile
            if (sent == 450 || sent == 1000 || sent == 700)
                wait_drained();

            if (track.held == DEPTH && tide_rising && $urandom_range(2) == 0)
                tide_rising = 1'b0;
            else if (track.held == 0 && !tide_rising)
                tide_rising = 1'b1;
            else if ($urandom_range(39) == 0)
                tide_rising = ~tide_rising;

            roll = $urandom_range(99);
            if (roll < 8)
                c = CMD_REVERSE;
            else if (roll < (tide_rising ? 78 : 30))
                c = ($urandom_range(1) == 0) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
            else
                c = CMD_POP_FRONT;
            send_request(c, pick_word());
            sent++;

            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 30);
                if ($urandom_range(3) != 0)
                    sender_gap($urandom_range(1, 12));
            end else begin
                burst_left--;
            end
        end

        cmd_bus.valid <= 1'b0;
        waited = 0;
        while (track.pending() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (8) @(posedge i_clk);
        if (track.pending() != 0)
            track.report($sformatf("%0d results never arrived", track.pending()));

        if (track.fail_count == 0) begin
            $display("double_ended_queue regression: pass");
        end else begin
            $display("double_ended_queue regression: fail");
        end
        $finish;
    end

    // watchdog: far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("double_ended_queue regression: fail");
        $finish;
    end

endmodule
